@@ sv/tpd_pkg.sv @@
// Package for the priority task dispatcher: field widths, default sizes,
// item kind codes and sequencer state codes. No dependencies.
package tpd_pkg;

    localparam int unsigned NUM_TASKS_DEF = 32;
    localparam int unsigned PRIO_BITS_DEF = 8;

    localparam int unsigned KIND_W   = 3;
    localparam int unsigned ID_W     = 5;
    localparam int unsigned LINE_W   = 5;
    localparam int unsigned MASK_W   = 32;
    localparam int unsigned PREQ_W   = 8;

    typedef enum logic [KIND_W-1:0] {
        KIND_REG      = 3'd0,
        KIND_UNREG    = 3'd1,
        KIND_WAKE_ID  = 3'd2,
        KIND_WAKE_IRQ = 3'd3,
        KIND_DISPATCH = 3'd4,
        KIND_FINISH   = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_FREE = 4'b0010,
        ST_CUR  = 4'b0100,
        ST_SCAN = 4'b1000
    } t_state;

endpackage

@@ sv/tpd_if.sv @@
// Valid/ready channel interfaces for the dispatcher's input and result words.
// Depends on tpd_pkg.
interface tpd_in_if;
    import tpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   task_id;
    logic [LINE_W-1:0] irq_line;
    logic [MASK_W-1:0] irq_mask;
    logic [PREQ_W-1:0] priority_req;
    logic              ret_nonzero;

    modport source (output valid, kind, task_id, irq_line, irq_mask, priority_req,
                    ret_nonzero, input ready);
    modport sink   (input valid, kind, task_id, irq_line, irq_mask, priority_req,
                    ret_nonzero, output ready);
endinterface

interface tpd_out_if;
    import tpd_pkg::*;

    logic            valid;
    logic            ready;
    logic            status;
    logic [ID_W-1:0] run_id;

    modport source (output valid, status, run_id, input ready);
    modport sink   (input valid, status, run_id, output ready);
endinterface

@@ sv/priority_task_dispatcher_top.sv @@
// Priority task dispatcher: valid bits in flops, priorities and interrupt
// masks in two RAMs, one shared compare walked by a scan counter.
// Depends on tpd_pkg, tpd_if and tpd_ram.
//
// Usage:
//   i_in carries one command word (register, unregister, wake by id, wake by
//   interrupt, dispatch, finish); o_out returns one result word per command
//   with status (1 = table full) and run_id.
//   Unregister, wake by id, finish and unused kinds: the result word follows
//   in the cycle after the command. Register: a walk from entry 1 up to the
//   lowest free entry, or to the last one for a full table. Wake by interrupt
//   and dispatch: a scan over the RAM read port, one entry a cycle.
//   One command is in flight at a time: i_in.ready is low while a command
//   runs and while its result word waits in the output register.
//   Throughput: the next command is taken the cycle after the result word.
//   A stalled receiver holds the result word and blocks further commands.
//   Reset: only the idle task is registered and pending, idle is current,
//   no wake bits. The RAMs are not cleared; entries are read only once
//   registered, and the idle task's priority is forced to zero.
module priority_task_dispatcher_top #(
    parameter int unsigned NUM_TASKS = tpd_pkg::NUM_TASKS_DEF,
    parameter int unsigned PRIO_BITS = tpd_pkg::PRIO_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tpd_in_if.sink    i_in,
    tpd_out_if.source o_out
);
    import tpd_pkg::*;

    localparam int unsigned IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(NUM_TASKS - 1);
    localparam logic [IDX_W-1:0] IDX_FIRST = IDX_W'(1);
    localparam logic [ID_W:0]    ID_LIM    = (ID_W + 1)'(NUM_TASKS);

    t_state                r_state, n_state;
    logic [NUM_TASKS-1:0]  r_valid, n_valid;
    logic [NUM_TASKS-1:0]  r_pend,  n_pend;
    logic [NUM_TASKS-1:0]  r_wake,  n_wake;
    logic [IDX_W-1:0]      r_cur,   n_cur;
    logic [IDX_W-1:0]      r_idx,   n_idx;
    logic                  r_iss,   n_iss;
    logic                  r_pv,    n_pv;
    logic [IDX_W-1:0]      r_pidx,  n_pidx;
    logic                  r_load,  n_load;
    logic [PRIO_BITS-1:0]  r_thr,   n_thr;
    logic [IDX_W-1:0]      r_best,  n_best;
    logic                  r_ovld,  n_ovld;
    logic                  r_ostat, n_ostat;
    logic [ID_W-1:0]       r_orun,  n_orun;

    logic [KIND_W-1:0]     r_kind;
    logic [LINE_W-1:0]     r_line;
    logic [MASK_W-1:0]     r_mask_in;
    logic [PRIO_BITS-1:0]  r_prio_in;

    logic                  accept;
    logic                  id_ok;
    logic [IDX_W-1:0]      tid;
    logic                  ram_we;
    logic [IDX_W-1:0]      ram_raddr;
    logic [PRIO_BITS-1:0]  rd_prio;
    logic [MASK_W-1:0]     rd_mask;
    logic [IDX_W-1:0]      fin_cur;

    assign i_in.ready   = (r_state == ST_IDLE) && !r_ovld;
    assign accept       = i_in.valid && i_in.ready;
    assign id_ok        = {1'b0, i_in.task_id} < ID_LIM;
    assign tid          = i_in.task_id[IDX_W-1:0];
    assign ram_raddr    = (r_state == ST_CUR) ? r_cur : r_idx;

    assign o_out.valid  = r_ovld;
    assign o_out.status = r_ostat;
    assign o_out.run_id = r_orun;

    tpd_ram #(.WIDTH(PRIO_BITS), .DEPTH(NUM_TASKS), .AW(IDX_W)) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_prio_in),
        .i_raddr (ram_raddr),
        .o_rdata (rd_prio)
    );

    tpd_ram #(.WIDTH(MASK_W), .DEPTH(NUM_TASKS), .AW(IDX_W)) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_idx),
        .i_wdata (r_mask_in),
        .i_raddr (ram_raddr),
        .o_rdata (rd_mask)
    );

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_pend  = r_pend;
        n_wake  = r_wake;
        n_cur   = r_cur;
        n_idx   = r_idx;
        n_iss   = r_iss;
        n_pv    = r_pv;
        n_pidx  = r_pidx;
        n_load  = r_load;
        n_thr   = r_thr;
        n_best  = r_best;
        n_ovld  = r_ovld;
        n_ostat = r_ostat;
        n_orun  = r_orun;
        ram_we  = 1'b0;
        fin_cur = r_cur;

        if (r_ovld && o_out.ready) begin
            n_ovld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_ostat = 1'b0;
                    n_orun  = ID_W'(r_cur);
                    case (i_in.kind)
                        KIND_REG: begin
                            n_state = ST_FREE;
                            n_idx   = IDX_FIRST;
                        end
                        KIND_UNREG: begin
                            n_ovld = 1'b1;
                            if (id_ok && (i_in.task_id != '0)) begin
                                n_pend[tid]  = 1'b0;
                                n_valid[tid] = 1'b0;
                            end
                        end
                        KIND_WAKE_ID: begin
                            n_ovld = 1'b1;
                            if (id_ok) begin
                                n_wake[tid] = 1'b1;
                            end
                        end
                        KIND_WAKE_IRQ: begin
                            n_state = ST_SCAN;
                            n_idx   = IDX_FIRST;
                            n_iss   = 1'b1;
                            n_pv    = 1'b0;
                            n_load  = 1'b0;
                        end
                        KIND_DISPATCH: begin
                            n_state = ST_CUR;
                            n_pend  = r_pend | r_wake;
                            n_wake  = '0;
                        end
                        KIND_FINISH: begin
                            n_ovld = 1'b1;
                            if (!i_in.ret_nonzero || !r_valid[r_cur]) begin
                                n_pend[r_cur] = 1'b0;
                            end
                        end
                        default: begin
                            n_ovld = 1'b1;
                        end
                    endcase
                end
            end

            ST_FREE: begin
                if (!r_valid[r_idx]) begin
                    ram_we         = 1'b1;
                    n_valid[r_idx] = 1'b1;
                    n_ovld         = 1'b1;
                    n_ostat        = 1'b0;
                    n_orun         = ID_W'(r_idx);
                    n_state        = ST_IDLE;
                end else if (r_idx == IDX_LAST) begin
                    n_ovld  = 1'b1;
                    n_ostat = 1'b1;
                    n_orun  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            ST_CUR: begin
                n_state = ST_SCAN;
                n_idx   = IDX_FIRST;
                n_iss   = 1'b1;
                n_pv    = 1'b0;
                n_load  = 1'b1;
                n_best  = '0;
            end

            ST_SCAN: begin
                n_load = 1'b0;
                n_pv   = r_iss;
                if (r_iss) begin
                    n_pidx = r_idx;
                    if (r_idx == IDX_LAST) begin
                        n_iss = 1'b0;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
                // threshold starts at the current task's priority; idle is zero
                if (r_load) begin
                    n_thr = (r_cur == '0) ? '0 : rd_prio;
                end
                if (r_pv) begin
                    if (r_kind == KIND_WAKE_IRQ) begin
                        if (r_valid[r_pidx] && rd_mask[r_line]) begin
                            n_wake[r_pidx] = 1'b1;
                        end
                    end else if ((r_pidx != r_cur) && r_valid[r_pidx] && r_pend[r_pidx]
                                 && (rd_prio >= r_thr)) begin
                        n_best = r_pidx;
                        n_thr  = rd_prio;
                    end
                    if (r_pidx == IDX_LAST) begin
                        n_state = ST_IDLE;
                        n_ovld  = 1'b1;
                        n_ostat = 1'b0;
                        if (r_kind == KIND_DISPATCH) begin
                            if (n_best != '0) begin
                                fin_cur = n_best;
                            end else if (!r_pend[r_cur]) begin
                                fin_cur = '0;
                            end
                            n_cur = fin_cur;
                        end
                        n_orun = ID_W'(fin_cur);
                    end
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= NUM_TASKS'(1);
            r_pend  <= NUM_TASKS'(1);
            r_wake  <= '0;
            r_cur   <= '0;
            r_idx   <= '0;
            r_iss   <= 1'b0;
            r_pv    <= 1'b0;
            r_load  <= 1'b0;
            r_best  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_pend  <= n_pend;
            r_wake  <= n_wake;
            r_cur   <= n_cur;
            r_idx   <= n_idx;
            r_iss   <= n_iss;
            r_pv    <= n_pv;
            r_load  <= n_load;
            r_best  <= n_best;
            r_ovld  <= n_ovld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx  <= n_pidx;
        r_thr   <= n_thr;
        r_ostat <= n_ostat;
        r_orun  <= n_orun;
        if (accept) begin
            r_kind    <= i_in.kind;
            r_line    <= i_in.irq_line;
            r_mask_in <= i_in.irq_mask;
            r_prio_in <= PRIO_BITS'(i_in.priority_req);
        end
    end

endmodule

@@ sv/tpd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tpd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/tpd_chk.sv @@
// Port-level checker for the priority task dispatcher, bound to the top level.
// Depends on tpd_pkg for field widths.
module tpd_chk (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic                   i_status,
    input logic [tpd_pkg::ID_W-1:0] i_run_id
);
    import tpd_pkg::*;

    // one command word at a time: nothing taken while a result word waits
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while result word pending");

    a_no_b2b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input ready straight after an accepted word");

    a_full_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status) |-> (i_run_id == '0))
        else $error("table-full result with non-idle run_id");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_run_id)))
        else $error("stalled result word changed");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word valid after reset");

endmodule

bind priority_task_dispatcher_top tpd_chk u_tpd_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_status    (o_out.status),
    .i_run_id    (o_out.run_id)
);
